@@ hdl/mita_pkg.sv @@
package mita_pkg;

  localparam int COORD_BITS_DEF = 10;

  localparam int SUM_W     = 63;
  localparam int NUM_SUMS  = 7;
  localparam int NUM_FACS  = 6;
  localparam int TERM_W    = 3;

  // accumulator order
  localparam logic [TERM_W-1:0] TERM_XX  = 3'd0;
  localparam logic [TERM_W-1:0] TERM_YY  = 3'd1;
  localparam logic [TERM_W-1:0] TERM_ZZ  = 3'd2;
  localparam logic [TERM_W-1:0] TERM_YZ  = 3'd3;
  localparam logic [TERM_W-1:0] TERM_XZ  = 3'd4;
  localparam logic [TERM_W-1:0] TERM_XY  = 3'd5;
  localparam logic [TERM_W-1:0] TERM_VOL = 3'd6;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef logic signed [SUM_W-1:0] sum_t;

  localparam sum_t SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam sum_t SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef struct packed {
    logic              not_empty;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

  // triple product a.(b x c) fits 3n+1 signed bits
  function automatic int det_width(input int n);
    return 3 * n + 1;
  endfunction

  // 2*(S_u+S_v) and -P_uv both fit 2n+4 signed bits
  function automatic int fac_width(input int n);
    return 2 * n + 4;
  endfunction

  // queue entry: {last, det, f5 .. f0}
  function automatic int entry_width(input int n);
    return 1 + det_width(n) + NUM_FACS * fac_width(n);
  endfunction

  function automatic sum_t sat_add(input sum_t a, input sum_t b);
    logic signed [SUM_W:0] s;
    s = (SUM_W+1)'(a) + (SUM_W+1)'(b);
    if (s[SUM_W] != s[SUM_W-1])
      return s[SUM_W] ? SUM_MIN : SUM_MAX;
    return s[SUM_W-1:0];
  endfunction

  function automatic sum_t clamp64(input logic signed [63:0] v);
    if (v[63] != v[62])
      return v[63] ? SUM_MIN : SUM_MAX;
    return v[SUM_W-1:0];
  endfunction

endpackage

@@ hdl/mita_front.sv @@
module mita_front #(
  parameter int COORD_BITS = mita_pkg::COORD_BITS_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            in_valid,
  output logic                                            in_stall,
  input  logic signed [COORD_BITS-1:0]                    ax,
  input  logic signed [COORD_BITS-1:0]                    ay,
  input  logic signed [COORD_BITS-1:0]                    az,
  input  logic signed [COORD_BITS-1:0]                    bx,
  input  logic signed [COORD_BITS-1:0]                    by_coord,
  input  logic signed [COORD_BITS-1:0]                    bz,
  input  logic signed [COORD_BITS-1:0]                    cx,
  input  logic signed [COORD_BITS-1:0]                    cy,
  input  logic signed [COORD_BITS-1:0]                    cz,
  input  logic                                            last_triangle,
  input  mita_pkg::q_stat_t                               q_stat,
  output logic                                            q_push,
  output logic [mita_pkg::entry_width(COORD_BITS)-1:0]    q_entry
);

  localparam int N  = COORD_BITS;
  localparam int TW = N + 2;
  localparam int MW = 2 * N + 1;
  localparam int SW = 2 * N + 2;
  localparam int CW = 2 * N + 3;
  localparam int DW = mita_pkg::det_width(N);
  localparam int FW = mita_pkg::fac_width(N);

  logic accept;

  logic signed [TW-1:0] tx, ty, tz;
  logic signed [MW-1:0] m0_next, m1_next, m2_next;
  logic signed [SW-1:0] sx_next, sy_next, sz_next;
  logic signed [CW-1:0] cyz_next, cxz_next, cxy_next;

  // stage 1 registers
  logic                 s1_valid;
  logic                 s1_last;
  logic signed [N-1:0]  s1_ax, s1_ay, s1_az;
  logic signed [MW-1:0] m0, m1, m2;
  logic signed [SW-1:0] sx, sy, sz;
  logic signed [CW-1:0] cyz, cxz, cxy;

  logic signed [DW-1:0] d0, d1, d2, det;
  logic signed [FW-1:0] fac [mita_pkg::NUM_FACS];

  // credit check: queue slots plus the item in stage 1
  assign in_stall = ((mita_pkg::QCNT_W+1)'(q_stat.count) + (mita_pkg::QCNT_W+1)'(s1_valid))
                    >= (mita_pkg::QCNT_W+1)'(mita_pkg::QUEUE_DEPTH);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    tx = TW'(ax) + TW'(bx) + TW'(cx);
    ty = TW'(ay) + TW'(by_coord) + TW'(cy);
    tz = TW'(az) + TW'(bz) + TW'(cz);

    m0_next = MW'(by_coord) * MW'(cz) - MW'(bz) * MW'(cy);
    m1_next = MW'(bz) * MW'(cx) - MW'(bx) * MW'(cz);
    m2_next = MW'(bx) * MW'(cy) - MW'(by_coord) * MW'(cx);

    sx_next = SW'(ax) * SW'(tx) + SW'(bx) * SW'(bx) + SW'(bx) * SW'(cx)
            + SW'(cx) * SW'(cx);
    sy_next = SW'(ay) * SW'(ty) + SW'(by_coord) * SW'(by_coord)
            + SW'(by_coord) * SW'(cy) + SW'(cy) * SW'(cy);
    sz_next = SW'(az) * SW'(tz) + SW'(bz) * SW'(bz) + SW'(bz) * SW'(cz)
            + SW'(cz) * SW'(cz);

    cyz_next = CW'(ty) * CW'(tz) + CW'(ay) * CW'(az) + CW'(by_coord) * CW'(bz)
             + CW'(cy) * CW'(cz);
    cxz_next = CW'(tx) * CW'(tz) + CW'(ax) * CW'(az) + CW'(bx) * CW'(bz)
             + CW'(cx) * CW'(cz);
    cxy_next = CW'(tx) * CW'(ty) + CW'(ax) * CW'(ay) + CW'(bx) * CW'(by_coord)
             + CW'(cx) * CW'(cy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1_last <= last_triangle;
      s1_ax   <= ax;
      s1_ay   <= ay;
      s1_az   <= az;
      m0      <= m0_next;
      m1      <= m1_next;
      m2      <= m2_next;
      sx      <= sx_next;
      sy      <= sy_next;
      sz      <= sz_next;
      cyz     <= cyz_next;
      cxz     <= cxz_next;
      cxy     <= cxy_next;
    end
  end

  always_comb begin
    d0  = DW'(s1_ax) * DW'(m0);
    d1  = DW'(s1_ay) * DW'(m1);
    d2  = DW'(s1_az) * DW'(m2);
    det = d0 + d1 + d2;

    fac[mita_pkg::TERM_XX] = (FW'(sy) + FW'(sz)) <<< 1;
    fac[mita_pkg::TERM_YY] = (FW'(sx) + FW'(sz)) <<< 1;
    fac[mita_pkg::TERM_ZZ] = (FW'(sx) + FW'(sy)) <<< 1;
    fac[mita_pkg::TERM_YZ] = -FW'(cyz);
    fac[mita_pkg::TERM_XZ] = -FW'(cxz);
    fac[mita_pkg::TERM_XY] = -FW'(cxy);
  end

  assign q_push  = s1_valid;
  assign q_entry = {s1_last, det,
                    fac[mita_pkg::TERM_XY], fac[mita_pkg::TERM_XZ], fac[mita_pkg::TERM_YZ],
                    fac[mita_pkg::TERM_ZZ], fac[mita_pkg::TERM_YY], fac[mita_pkg::TERM_XX]};

endmodule

@@ hdl/mita_queue.sv @@
module mita_queue #(
  parameter int WIDTH = mita_pkg::entry_width(mita_pkg::COORD_BITS_DEF)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [WIDTH-1:0]   wr_data,
  input  logic               pop,
  output logic [WIDTH-1:0]   rd_data,
  output mita_pkg::q_stat_t  stat
);

  logic [WIDTH-1:0]                  mem [mita_pkg::QUEUE_DEPTH];
  logic [mita_pkg::QPTR_W-1:0]       wr_ptr;
  logic [mita_pkg::QPTR_W-1:0]       rd_ptr;
  logic [mita_pkg::QCNT_W-1:0]       count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + mita_pkg::QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + mita_pkg::QPTR_W'(1);
      if (push && !pop)
        count <= count + mita_pkg::QCNT_W'(1);
      else if (pop && !push)
        count <= count - mita_pkg::QCNT_W'(1);
    end
    if (push) mem[wr_ptr] <= wr_data;
  end

  assign rd_data        = mem[rd_ptr];
  assign stat.not_empty = (count != '0);
  assign stat.count     = count;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && !pop && count == mita_pkg::QCNT_W'(mita_pkg::QUEUE_DEPTH)))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && count == '0))
    else $error("queue pop while empty");

endmodule

@@ hdl/mita_back.sv @@
module mita_back #(
  parameter int COORD_BITS = mita_pkg::COORD_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  mita_pkg::q_stat_t                             q_stat,
  input  logic [mita_pkg::entry_width(COORD_BITS)-1:0]  q_entry,
  output logic                                          q_pop,
  output logic                                          out_valid,
  input  logic                                          out_stall,
  output mita_pkg::sum_t                                out_sum [mita_pkg::NUM_SUMS]
);

  localparam int N  = COORD_BITS;
  localparam int DW = mita_pkg::det_width(N);
  localparam int FW = mita_pkg::fac_width(N);
  localparam int EW = mita_pkg::entry_width(N);
  localparam int LW = DW / 2;
  localparam int HW = DW - LW;
  localparam int PW = 5 * N + 4;

  logic                 head_last;
  logic signed [DW-1:0] head_det;
  logic signed [FW-1:0] fac [mita_pkg::NUM_SUMS];
  logic signed [FW-1:0] fsel;

  logic [mita_pkg::TERM_W-1:0] k;
  logic hold, issue, load;

  // product stage
  logic                        p_valid;
  logic                        p_last;
  logic [mita_pkg::TERM_W-1:0] p_k;
  logic signed [LW+FW:0]       p_lo, p_lo_next;
  logic signed [HW+FW-1:0]     p_hi, p_hi_next;

  // term stage
  logic                        t_valid;
  logic                        t_last;
  logic [mita_pkg::TERM_W-1:0] t_k;
  mita_pkg::sum_t              t_val;

  logic signed [PW-1:0] prod;
  mita_pkg::sum_t       acc     [mita_pkg::NUM_SUMS];
  mita_pkg::sum_t       acc_new [mita_pkg::NUM_SUMS];
  mita_pkg::sum_t       acc_sum;

  assign head_last = q_entry[EW-1];
  assign head_det  = q_entry[EW-2 -: DW];

  always_comb begin
    for (int i = 0; i < mita_pkg::NUM_FACS; i++)
      fac[i] = q_entry[i*FW +: FW];
    fac[mita_pkg::TERM_VOL] = FW'(1);
    fsel = fac[k];
  end

  // wide product split over two multipliers, recombined next stage
  assign p_lo_next = (LW+FW+1)'($signed({1'b0, head_det[LW-1:0]})) * (LW+FW+1)'(fsel);
  assign p_hi_next = (HW+FW)'($signed(head_det[DW-1:LW])) * (HW+FW)'(fsel);

  // freeze the back pipe while a finished total cannot leave
  assign hold  = t_valid && t_last && out_valid && out_stall;
  assign issue = q_stat.not_empty && !hold;
  assign q_pop = issue && (k == mita_pkg::TERM_VOL);
  assign load  = !hold && t_valid && t_last;

  assign prod = (PW'(p_hi) <<< LW) + PW'(p_lo);

  always_comb begin
    acc_sum = mita_pkg::sat_add(acc[t_k], t_val);
    for (int i = 0; i < mita_pkg::NUM_SUMS; i++)
      acc_new[i] = (t_k == mita_pkg::TERM_W'(i)) ? acc_sum : acc[i];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k         <= '0;
      p_valid   <= 1'b0;
      t_valid   <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < mita_pkg::NUM_SUMS; i++)
        acc[i] <= '0;
    end else begin
      if (!hold) begin
        p_valid <= issue;
        t_valid <= p_valid;
        if (issue)
          k <= q_pop ? '0 : k + mita_pkg::TERM_W'(1);
        if (t_valid) begin
          if (t_last) begin
            for (int i = 0; i < mita_pkg::NUM_SUMS; i++)
              acc[i] <= '0;
          end else begin
            acc[t_k] <= acc_sum;
          end
        end
      end
      if (load)
        out_valid <= 1'b1;
      else if (!out_stall)
        out_valid <= 1'b0;
    end

    if (!hold) begin
      p_last <= q_pop && head_last;
      p_k    <= k;
      p_lo   <= p_lo_next;
      p_hi   <= p_hi_next;
      t_last <= p_last;
      t_k    <= p_k;
      t_val  <= mita_pkg::clamp64(64'(prod));
    end
    if (load) begin
      for (int i = 0; i < mita_pkg::NUM_SUMS; i++)
        out_sum[i] <= acc_new[i];
    end
  end

  a_hold_keeps_total: assert property (@(posedge clk) disable iff (rst)
    hold |=> (t_valid && t_last && out_valid))
    else $error("pending total lost while output stalled");

  a_pop_on_last_term: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (k == mita_pkg::TERM_VOL && q_stat.not_empty))
    else $error("queue entry released before all terms issued");

endmodule

@@ hdl/mesh_inertia_tensor_accumulate.sv @@
// Accumulates the inertia tensor of a closed triangle mesh about the origin.
// Each accepted triangle adds its signed tetrahedron terms to seven saturating
// 63-bit sums (six tensor entries scaled by 120, plus six times the volume);
// the triangle flagged last_triangle produces one result holding the totals
// and clears the sums. The front end registers an accepted triangle and in
// the next cycle writes the triple product and six tensor factors into a
// four-entry queue. The back end's one shared, split multiplier handles one
// of seven terms per cycle unless a stalled total holds it; the next queued
// triangle starts once all terms of the current one have issued, and the
// totals are registered out after the last term leaves the term stage. At
// most four triangles wait ahead of the multiplier (queue plus front stage,
// counting the one in progress); in_stall rises once the two reach four.
module mesh_inertia_tensor_accumulate #(
  parameter int COORD_BITS = mita_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_BITS-1:0]  ax,
  input  logic signed [COORD_BITS-1:0]  ay,
  input  logic signed [COORD_BITS-1:0]  az,
  input  logic signed [COORD_BITS-1:0]  bx,
  input  logic signed [COORD_BITS-1:0]  by_coord,
  input  logic signed [COORD_BITS-1:0]  bz,
  input  logic signed [COORD_BITS-1:0]  cx,
  input  logic signed [COORD_BITS-1:0]  cy,
  input  logic signed [COORD_BITS-1:0]  cz,
  input  logic                          last_triangle,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [62:0]            ixx_sum,
  output logic signed [62:0]            iyy_sum,
  output logic signed [62:0]            izz_sum,
  output logic signed [62:0]            iyz_sum,
  output logic signed [62:0]            ixz_sum,
  output logic signed [62:0]            ixy_sum,
  output logic signed [62:0]            six_volume
);

  localparam int EW = mita_pkg::entry_width(COORD_BITS);

  mita_pkg::q_stat_t q_stat;
  logic              q_push;
  logic              q_pop;
  logic [EW-1:0]     push_entry;
  logic [EW-1:0]     head_entry;
  mita_pkg::sum_t    out_sum [mita_pkg::NUM_SUMS];

  mita_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .ax            (ax),
    .ay            (ay),
    .az            (az),
    .bx            (bx),
    .by_coord      (by_coord),
    .bz            (bz),
    .cx            (cx),
    .cy            (cy),
    .cz            (cz),
    .last_triangle (last_triangle),
    .q_stat        (q_stat),
    .q_push        (q_push),
    .q_entry       (push_entry)
  );

  mita_queue #(
    .WIDTH (EW)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (push_entry),
    .pop     (q_pop),
    .rd_data (head_entry),
    .stat    (q_stat)
  );

  mita_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .q_entry   (head_entry),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_sum   (out_sum)
  );

  assign ixx_sum    = out_sum[mita_pkg::TERM_XX];
  assign iyy_sum    = out_sum[mita_pkg::TERM_YY];
  assign izz_sum    = out_sum[mita_pkg::TERM_ZZ];
  assign iyz_sum    = out_sum[mita_pkg::TERM_YZ];
  assign ixz_sum    = out_sum[mita_pkg::TERM_XZ];
  assign ixy_sum    = out_sum[mita_pkg::TERM_XY];
  assign six_volume = out_sum[mita_pkg::TERM_VOL];

endmodule

@@ sim/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef mita_pkg::sum_t sum_t;

  localparam int CW = mita_pkg::COORD_BITS_DEF;
  localparam int MAXC = 2 ** (CW - 1) - 1;
  localparam int MINC = -(2 ** (CW - 1));
  localparam longint SAT_HI = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam longint SAT_LO = -SAT_HI - 1;
  // settle time for the back end to drain four queued triangles, plus pipeline slack
  localparam int SETTLE = 64;
  // long meshes of one corner triangle build large sums of either sign
  localparam int HEAVY_LEN = 150;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    coord_t p [3][3];  // [vertex a,b,c][axis x,y,z]
    logic   last;
  } tri_t;

  typedef struct {
    sum_t xx, yy, zz, yz, xz, xy, vol;
  } totals_t;

  class tensor_scoreboard;
    longint  moment [6];
    longint  volume;
    totals_t totals_due [$];
    int      errors;

    function new();
      clear_sums();
      errors = 0;
    endfunction

    function void clear_sums();
      for (int i = 0; i < 6; i++) moment[i] = 0;
      volume = 0;
    endfunction

    function longint clamp_sum(longint v);
      if (v > SAT_HI) return SAT_HI;
      if (v < SAT_LO) return SAT_LO;
      return v;
    endfunction

    function longint limit_product(longint x, longint y);
      logic signed [127:0] wx, wy, prod;
      wx = x;
      wy = y;
      prod = wx * wy;
      if (prod > SAT_HI) return SAT_HI;
      if (prod < SAT_LO) return SAT_LO;
      return longint'(prod);
    endfunction

    function int pending();
      return totals_due.size();
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 100) $display("MISMATCH @%0t: %s", $realtime, msg);
    endfunction

    function void note_triangle(tri_t t);
      longint a [3], b [3], c [3], tsum [3], self_sq [3], pair [3];
      longint det;
      longint term [6];
      totals_t exp_tot;
      for (int u = 0; u < 3; u++) begin
        a[u] = t.p[0][u];
        b[u] = t.p[1][u];
        c[u] = t.p[2][u];
        tsum[u] = a[u] + b[u] + c[u];
        self_sq[u] = a[u] * tsum[u] + b[u] * b[u] + b[u] * c[u] + c[u] * c[u];
      end
      // pair index follows the off-diagonal order yz, xz, xy
      for (int k = 0; k < 3; k++) begin
        int u, v;
        u = (k == 2) ? 0 : k == 1 ? 0 : 1;
        v = (k == 2) ? 1 : 2;
        pair[k] = tsum[u] * tsum[v] + a[u] * a[v] + b[u] * b[v] + c[u] * c[v];
      end
      det = a[0] * (b[1] * c[2] - b[2] * c[1])
          + a[1] * (b[2] * c[0] - b[0] * c[2])
          + a[2] * (b[0] * c[1] - b[1] * c[0]);
      term[0] = limit_product(det, 2 * (self_sq[1] + self_sq[2]));
      term[1] = limit_product(det, 2 * (self_sq[0] + self_sq[2]));
      term[2] = limit_product(det, 2 * (self_sq[0] + self_sq[1]));
      for (int k = 0; k < 3; k++) term[3 + k] = limit_product(det, -pair[k]);
      for (int i = 0; i < 6; i++) moment[i] = clamp_sum(moment[i] + term[i]);
      volume = clamp_sum(volume + clamp_sum(det));
      if (t.last) begin
        exp_tot.xx  = sum_t'(moment[0]);
        exp_tot.yy  = sum_t'(moment[1]);
        exp_tot.zz  = sum_t'(moment[2]);
        exp_tot.yz  = sum_t'(moment[3]);
        exp_tot.xz  = sum_t'(moment[4]);
        exp_tot.xy  = sum_t'(moment[5]);
        exp_tot.vol = sum_t'(volume);
        totals_due.insert(totals_due.size(), exp_tot);
        clear_sums();
      end
    endfunction

    function void compare_field(string name, sum_t got, sum_t want);
      if (got !== want) report($sformatf("%s got %0d expected %0d", name, got, want));
    endfunction

    function void check_totals(totals_t got);
      totals_t want;
      if (totals_due.size() == 0) begin
        report("result transfer with no mesh total outstanding");
        return;
      end
      want = totals_due.pop_front();
      compare_field("ixx_sum", got.xx, want.xx);
      compare_field("iyy_sum", got.yy, want.yy);
      compare_field("izz_sum", got.zz, want.zz);
      compare_field("iyz_sum", got.yz, want.yz);
      compare_field("ixz_sum", got.xz, want.xz);
      compare_field("ixy_sum", got.xy, want.xy);
      compare_field("six_volume", got.vol, want.vol);
    endfunction
  endclass

  logic   clk = 1'b0;
  logic   rst;
  logic   in_valid;
  logic   in_stall;
  coord_t ax, ay, az, bx, by_coord, bz, cx, cy, cz;
  logic   last_triangle;
  logic   out_valid;
  logic   out_stall;
  sum_t   ixx_sum, iyy_sum, izz_sum, iyz_sum, ixz_sum, ixy_sum, six_volume;

  tensor_scoreboard sb = new();
  int gap_pct;
  int stall_pct;

  mesh_inertia_tensor_accumulate uut (.*);

  always #4 clk = ~clk;

  initial begin
    #5ms;
    $display("mesh_inertia_tensor_accumulate regression: fail");
    $finish;
  end

  // receiver back-pressure in bursts
  initial begin
    int stall_left;
    stall_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct)
          stall_left = $urandom_range(1, 19);
      end
    end
  end

  always @(posedge clk) begin
    totals_t got;
    if (!rst && out_valid && !out_stall) begin
      got.xx  = ixx_sum;
      got.yy  = iyy_sum;
      got.zz  = izz_sum;
      got.yz  = iyz_sum;
      got.xz  = ixz_sum;
      got.xy  = ixy_sum;
      got.vol = six_volume;
      sb.check_totals(got);
    end
  end

  function automatic tri_t mk(input int a0, a1, a2, b0, b1, b2, c0, c1, c2,
                              input bit last);
    tri_t t;
    t.p[0][0] = coord_t'(a0); t.p[0][1] = coord_t'(a1); t.p[0][2] = coord_t'(a2);
    t.p[1][0] = coord_t'(b0); t.p[1][1] = coord_t'(b1); t.p[1][2] = coord_t'(b2);
    t.p[2][0] = coord_t'(c0); t.p[2][1] = coord_t'(c1); t.p[2][2] = coord_t'(c2);
    t.last = last;
    return t;
  endfunction

  function automatic tri_t make_triangle();
    tri_t t;
    int kind, pick;
    kind = $urandom_range(0, 99);
    for (int v = 0; v < 3; v++) begin
      for (int u = 0; u < 3; u++) begin
        if (kind < 35)
          t.p[v][u] = coord_t'($urandom);
        else if (kind < 55)
          t.p[v][u] = coord_t'(int'($urandom_range(0, 15)) - 8);
        else if (kind < 70)
          t.p[v][u] = $urandom_range(0, 1) ? coord_t'(MAXC) : coord_t'(MINC);
        else
          t.p[v][u] = coord_t'(int'($urandom_range(0, 255)) - 128);
      end
    end
    // repeated vertex: zero volume
    if (kind >= 90) begin
      pick = $urandom_range(0, 2);
      if (pick == 0) t.p[1] = t.p[0];
      else if (pick == 1) t.p[2] = t.p[0];
      else t.p[2] = t.p[1];
    end
    t.last = 1'b0;
    return t;
  endfunction

  task automatic send_triangle(input tri_t t);
    int gap;
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 19);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    ax <= t.p[0][0]; ay <= t.p[0][1];       az <= t.p[0][2];
    bx <= t.p[1][0]; by_coord <= t.p[1][1]; bz <= t.p[1][2];
    cx <= t.p[2][0]; cy <= t.p[2][1];       cz <= t.p[2][2];
    last_triangle <= t.last;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_triangle(t);
  endtask

  task automatic pause_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic send_mesh(input int n);
    tri_t t;
    for (int k = 0; k < n; k++) begin
      t = make_triangle();
      t.last = (k == n - 1);
      send_triangle(t);
    end
  endtask

  // same corner triangle over and over; odd vertex order flips the sign
  task automatic send_heavy_mesh(input bit negative);
    tri_t base, t;
    int rot;
    base = mk(MAXC, MAXC, MAXC, MAXC, MINC, MAXC, MAXC, MAXC, MINC, 1'b0);
    if (negative) begin
      t = base;
      base.p[1] = t.p[2];
      base.p[2] = t.p[1];
    end
    for (int k = 0; k < HEAVY_LEN; k++) begin
      rot = $urandom_range(0, 2);
      for (int v = 0; v < 3; v++) t.p[v] = base.p[(v + rot) % 3];
      t.last = (k == HEAVY_LEN - 1);
      send_triangle(t);
    end
  endtask

  task automatic run_random_meshes(input int quota, input bit allow_idle);
    int sent, n, r;
    sent = 0;
    while (sent < quota) begin
      if (allow_idle) begin
        if ($urandom_range(0, 4) == 0) begin
          gap_pct = 0;
          stall_pct = 0;
        end else begin
          gap_pct = $urandom_range(5, 40);
          stall_pct = $urandom_range(5, 40);
        end
      end
      r = $urandom_range(0, 99);
      n = (r < 70) ? $urandom_range(1, 6) : (r < 95) ? $urandom_range(7, 30)
                                                     : $urandom_range(31, 80);
      send_mesh(n);
      sent += n;
    end
  endtask

  initial begin
    int waited;
    rst = 1'b1;
    in_valid = 1'b0;
    {ax, ay, az, bx, by_coord, bz, cx, cy, cz} = '0;
    last_triangle = 1'b0;
    gap_pct = 30;
    stall_pct = 30;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // single-triangle meshes at zero and at the coordinate extremes
    send_triangle(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
    send_triangle(mk(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, 1'b1));
    send_triangle(mk(MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC, 1'b1));
    send_triangle(mk(MAXC, MAXC, MAXC, MAXC, MINC, MAXC, MAXC, MAXC, MINC, 1'b1));
    send_triangle(mk(MAXC, MAXC, MAXC, MAXC, MAXC, MINC, MAXC, MINC, MAXC, 1'b1));
    // closed tetrahedron away from the origin
    send_triangle(mk(10, 10, 10, 10, 110, 10, 110, 10, 10, 1'b0));
    send_triangle(mk(10, 10, 10, 110, 10, 10, 10, 10, 110, 1'b0));
    send_triangle(mk(10, 10, 10, 10, 10, 110, 10, 110, 10, 1'b0));
    send_triangle(mk(110, 10, 10, 10, 110, 10, 10, 10, 110, 1'b1));
    // collinear, then mixed extremes, closed by a last triangle
    send_triangle(mk(1, 2, 3, 2, 4, 6, -3, -6, -9, 1'b0));
    send_triangle(mk(MINC, 0, MAXC, MAXC, MINC, 0, 0, MAXC, MINC, 1'b0));
    send_triangle(mk(MAXC, MINC, MINC, MINC, MAXC, MINC, MINC, MINC, MAXC, 1'b1));
    send_triangle(mk(1, 0, 0, 0, 1, 0, 0, 0, 1, 1'b1));
    send_triangle(mk(MINC, 0, 0, 0, MINC, 0, 0, 0, MINC, 1'b0));
    send_triangle(mk(MAXC, 0, 0, 0, 0, MAXC, 0, MAXC, 0, 1'b1));
    pause_until_drained();

    run_random_meshes(450, 1'b1);
    pause_until_drained();

    gap_pct = 3;
    stall_pct = 10;
    send_heavy_mesh(1'b0);
    send_heavy_mesh(1'b1);
    pause_until_drained();

    run_random_meshes(300, 1'b1);

    gap_pct = 0;
    stall_pct = 0;
    run_random_meshes(120, 1'b0);

    @(negedge clk);
    in_valid <= 1'b0;
    waited = 0;
    while (sb.pending() != 0 && waited < 20000) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE) @(negedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d mesh totals never arrived", sb.pending()));

    if (sb.errors == 0)
      $display("mesh_inertia_tensor_accumulate regression: pass");
    else
      $display("mesh_inertia_tensor_accumulate regression: fail");
    $finish;
  end

endmodule
